FILE: hdl/grid_line_cell_rasterizer_defines.svh
// ============================================================================
// Grid line cell rasterizer assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ============================================================================
`ifndef GRID_LINE_CELL_RASTERIZER_DEFINES_SVH
`define GRID_LINE_CELL_RASTERIZER_DEFINES_SVH

// Same-cycle implication.
`define GLCR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GLCR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/glcr_pkg.sv
// ============================================================================
// Grid line cell rasterizer package
// Widths, fixed-point constants, types and cell index helpers.
// ============================================================================
package glcr_pkg;

    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 8;
    localparam int MAX_CELLS  = 64;
    localparam int CELL_BITS  = 17;

    localparam int WIDE_BITS = COORD_BITS + 2;
    localparam int QUO_BITS  = FRAC_BITS + 1;
    localparam int QCNT_BITS = $clog2(QUO_BITS + 1);
    localparam int CNT_BITS  = (MAX_CELLS > 2) ? $clog2(MAX_CELLS) : 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [COORD_BITS:0]   diff_t;
    typedef logic signed [WIDE_BITS-1:0]  wide_t;
    typedef logic        [COORD_BITS-1:0] mag_t;
    typedef logic        [QUO_BITS-1:0]   quo_t;
    typedef logic signed [QUO_BITS:0]     stepq_t;
    typedef logic signed [CELL_BITS-1:0]  cell_t;

    localparam wide_t ONE_Q     = wide_t'(1 << FRAC_BITS);
    localparam wide_t FRAC_MASK = ONE_Q - wide_t'(1);

    // Cell index of x plus a fraction below one unit; frac is set when that
    // fraction is nonzero. Negative values map to trunc(v - 1.0).
    function automatic cell_t cell_of(input wide_t x, input logic frac);
        wide_t t;
        wide_t c;
        if (x >= 0) begin
            c = x >>> FRAC_BITS;
        end else begin
            t = ONE_Q - x - wide_t'(frac);
            c = -(t >>> FRAC_BITS);
        end
        return cell_t'(c);
    endfunction

    // Largest value whose truncation toward zero does not exceed that of me.
    function automatic wide_t trunc_bound(input wide_t me);
        wide_t masked;
        masked = (-me) & ~FRAC_MASK;
        if (me >= 0) begin
            return me | FRAC_MASK;
        end else if (masked == '0) begin
            return FRAC_MASK;
        end else begin
            return -masked;
        end
    endfunction

endpackage

FILE: hdl/glcr_div.sv
// ============================================================================
// Grid line cell rasterizer slope divider
// Restoring divider, one compare-subtract per cycle, for the per-cell slope.
// ============================================================================
module glcr_div import glcr_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic start,
    input  mag_t dividend,
    input  mag_t divisor,
    output logic done,
    output quo_t quotient,
    output mag_t remainder
);

    logic                 busy_reg;
    logic                 first_reg;
    logic                 done_reg;
    logic [QCNT_BITS-1:0] cnt_reg;
    mag_t                 rem_reg;
    quo_t                 quo_reg;

    logic [COORD_BITS:0] trial;
    logic                fits;
    mag_t                rem_next;

    // The quotient is dividend/divisor scaled by one unit; the dividend never
    // exceeds the divisor, so the partial remainder stays below twice the divisor.
    always_comb begin
        trial    = first_reg ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        fits     = trial >= {1'b0, divisor};
        rem_next = fits ? mag_t'(trial - {1'b0, divisor}) : mag_t'(trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                first_reg <= 1'b1;
                cnt_reg   <= QCNT_BITS'(QUO_BITS);
                rem_reg   <= dividend;
            end else if (busy_reg) begin
                rem_reg   <= rem_next;
                quo_reg   <= quo_t'({quo_reg, fits});
                first_reg <= 1'b0;
                cnt_reg   <= cnt_reg - QCNT_BITS'(1);
                if (cnt_reg == QCNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: hdl/grid_line_cell_rasterizer.sv
// ============================================================================
// Grid line cell rasterizer
// Walks one line segment per transaction and emits the grid cells it covers.
// ============================================================================
// Usage: the s_ channel carries one segment per transaction, two endpoints in
// signed Q15.8. The m_ channel returns one grid cell per transaction; the
// final cell of a segment has m_last_cell set, and m_cut_short is set on it
// when the walk was stopped by the limit of 64 cells.
// After a segment transaction the block computes the endpoint deltas and
// orders the endpoints, runs the slope divider (a start, nine quotient bits
// at one per cycle through a single compare-subtract unit and a done) and
// does a setup step before the first cell is presented.
// Throughput: one cell per cycle after that while the receiver takes each
// cell, produced by the one-step incremental walker.
// s_ready is high only while no segment is being worked on; the last cell of
// a segment may still wait in the output register when the next segment is
// taken. When the receiver stalls, the walk holds and the output register
// keeps its cell. Reset (aresetn low, synchronous) drops any segment and any
// waiting cell and leaves the block idle and ready.
// ============================================================================
`include "grid_line_cell_rasterizer_defines.svh"

module grid_line_cell_rasterizer import glcr_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  coord_t s_start_x,
    input  coord_t s_start_y,
    input  coord_t s_end_x,
    input  coord_t s_end_y,
    output logic   m_valid,
    input  logic   m_ready,
    output cell_t  m_cell_x,
    output cell_t  m_cell_y,
    output logic   m_last_cell,
    output logic   m_cut_short
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_ORDER,
        ST_DIV,
        ST_FIX,
        ST_WALK
    } state_t;

    state_t state_reg;

    // Captured endpoints and their deltas.
    coord_t sx_reg, sy_reg, ex_reg, ey_reg;
    diff_t  dx_reg, dy_reg;

    // Ordered segment: major start/end, minor start/end, slope operands.
    coord_t ms_reg, me_reg, ns_reg, ne_reg;
    mag_t   dmaj_reg;
    mag_t   dmin_mag_reg;
    logic   dmin_neg_reg;
    logic   y_major_reg;
    logic   flat_reg;
    logic   div_start_reg;

    // Walk limits and per-step increments.
    wide_t  bound_reg;
    wide_t  stop_lim_reg;
    wide_t  clamp_lim_reg;
    stepq_t step_q_reg;
    mag_t   step_r_reg;

    // Walk state.
    coord_t              m_pos_reg;
    coord_t              minor_reg;
    mag_t                frac_rem_reg;
    logic [CNT_BITS-1:0] cnt_reg;

    // Output register.
    logic  m_valid_reg;
    cell_t m_cell_x_reg, m_cell_y_reg;
    logic  m_last_cell_reg, m_cut_short_reg;

    // Divider.
    logic div_done;
    quo_t div_quo;
    mag_t div_rem;

    glcr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start_reg),
        .dividend  (dmin_mag_reg),
        .divisor   (dmaj_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // ------------------------------------------------------------------
    // Endpoint ordering. The swap follows the sign of the major delta, and
    // the minor slope sign flips with it.
    // ------------------------------------------------------------------
    diff_t abs_dx, abs_dy, d_maj, d_min;
    logic  y_major, swap, dmin_neg, flat;

    always_comb begin
        abs_dx   = (dx_reg < 0) ? -dx_reg : dx_reg;
        abs_dy   = (dy_reg < 0) ? -dy_reg : dy_reg;
        y_major  = abs_dy >= abs_dx;
        d_maj    = y_major ? dy_reg : dx_reg;
        d_min    = y_major ? dx_reg : dy_reg;
        swap     = d_maj < 0;
        dmin_neg = swap ? (d_min > 0) : (d_min < 0);
        flat     = (dx_reg == '0) || (dy_reg == '0);
    end

    // ------------------------------------------------------------------
    // Walk datapath. The minor coordinate is kept as an exact floor value
    // plus a remainder against the major delta, advanced by one slope step.
    // ------------------------------------------------------------------
    logic [COORD_BITS:0] rsum;
    logic                carry;
    mag_t                walk_rem_next;
    coord_t              walk_minor_next;
    coord_t              walk_pos_next;
    cell_t               cell_maj, cell_min;
    logic                at_end, at_cap, clamp, walk_last, out_free;

    always_comb begin
        rsum            = {1'b0, frac_rem_reg} + {1'b0, step_r_reg};
        carry           = rsum >= {1'b0, dmaj_reg};
        walk_rem_next   = carry ? mag_t'(rsum - {1'b0, dmaj_reg}) : mag_t'(rsum);
        walk_minor_next = coord_t'(wide_t'(minor_reg) + wide_t'(step_q_reg)
                                   + wide_t'(carry));
        walk_pos_next   = coord_t'(wide_t'(m_pos_reg) + ONE_Q);
        cell_maj        = cell_of(wide_t'(m_pos_reg), 1'b0);
        cell_min        = cell_of(wide_t'(minor_reg), frac_rem_reg != '0);
        at_end          = wide_t'(m_pos_reg) > stop_lim_reg;
        at_cap          = cnt_reg == CNT_BITS'(MAX_CELLS - 1);
        clamp           = !flat_reg && (wide_t'(m_pos_reg) > clamp_lim_reg);
        walk_last       = at_end || at_cap;
        out_free        = !m_valid_reg || m_ready;
    end

    // ------------------------------------------------------------------
    // Sequencer, datapath registers and output register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            div_start_reg <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        sx_reg    <= s_start_x;
                        sy_reg    <= s_start_y;
                        ex_reg    <= s_end_x;
                        ey_reg    <= s_end_y;
                        state_reg <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    dx_reg    <= diff_t'(ex_reg) - diff_t'(sx_reg);
                    dy_reg    <= diff_t'(ey_reg) - diff_t'(sy_reg);
                    state_reg <= ST_ORDER;
                end
                ST_ORDER: begin
                    if (y_major) begin
                        ms_reg <= swap ? ey_reg : sy_reg;
                        me_reg <= swap ? sy_reg : ey_reg;
                        ns_reg <= swap ? ex_reg : sx_reg;
                        ne_reg <= swap ? sx_reg : ex_reg;
                    end else begin
                        ms_reg <= swap ? ex_reg : sx_reg;
                        me_reg <= swap ? sx_reg : ex_reg;
                        ns_reg <= swap ? ey_reg : sy_reg;
                        ne_reg <= swap ? sy_reg : ey_reg;
                    end
                    dmaj_reg      <= mag_t'(y_major ? abs_dy : abs_dx);
                    dmin_mag_reg  <= mag_t'(y_major ? abs_dx : abs_dy);
                    dmin_neg_reg  <= dmin_neg;
                    y_major_reg   <= y_major;
                    flat_reg      <= flat;
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_DIV;
                end
                ST_DIV: begin
                    bound_reg <= trunc_bound(wide_t'(me_reg));
                    if (div_done) begin
                        state_reg <= ST_FIX;
                    end
                end
                ST_FIX: begin
                    // Turn the magnitude quotient into a floor quotient with a
                    // nonnegative remainder.
                    if (!dmin_neg_reg) begin
                        step_q_reg <= stepq_t'({1'b0, div_quo});
                        step_r_reg <= div_rem;
                    end else if (div_rem == '0) begin
                        step_q_reg <= -stepq_t'({1'b0, div_quo});
                        step_r_reg <= '0;
                    end else begin
                        step_q_reg <= ~stepq_t'({1'b0, div_quo});
                        step_r_reg <= dmaj_reg - div_rem;
                    end
                    stop_lim_reg  <= bound_reg - ONE_Q;
                    clamp_lim_reg <= wide_t'(me_reg) - ONE_Q;
                    m_pos_reg     <= ms_reg;
                    minor_reg     <= ns_reg;
                    frac_rem_reg  <= '0;
                    cnt_reg       <= '0;
                    state_reg     <= ST_WALK;
                end
                ST_WALK: begin
                    if (out_free) begin
                        m_valid_reg     <= 1'b1;
                        m_cell_x_reg    <= y_major_reg ? cell_min : cell_maj;
                        m_cell_y_reg    <= y_major_reg ? cell_maj : cell_min;
                        m_last_cell_reg <= walk_last;
                        m_cut_short_reg <= !at_end && at_cap;
                        if (walk_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            cnt_reg <= cnt_reg + CNT_BITS'(1);
                            if (clamp) begin
                                // Overshooting step lands on the end point,
                                // where the minor coordinate is exact.
                                m_pos_reg    <= me_reg;
                                minor_reg    <= ne_reg;
                                frac_rem_reg <= '0;
                            end else begin
                                m_pos_reg <= walk_pos_next;
                                if (!flat_reg) begin
                                    minor_reg    <= walk_minor_next;
                                    frac_rem_reg <= walk_rem_next;
                                end
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_cell_x    = m_cell_x_reg;
    assign m_cell_y    = m_cell_y_reg;
    assign m_last_cell = m_last_cell_reg;
    assign m_cut_short = m_cut_short_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `GLCR_ASSERT_IMP(a_cut_implies_last, m_valid && m_cut_short, m_last_cell,
        "cut_short set on a cell that is not the last")
    `GLCR_ASSERT_IMP(a_rem_below_major, (state_reg == ST_WALK) && !flat_reg,
        frac_rem_reg < dmaj_reg, "walk remainder not below the major delta")
    `GLCR_ASSERT_IMP(a_div_done_in_div, div_done, state_reg == ST_DIV,
        "divider finished outside the divide phase")
    `GLCR_ASSERT_NXT(a_last_ends_walk,
        (state_reg == ST_WALK) && out_free && walk_last,
        (state_reg == ST_IDLE) && m_valid && m_last_cell,
        "last cell did not end the walk")

endmodule
